// ===== rtl/uvst_pkg.sv =====
// Shared constants for the UV sphere tessellator: codes, latencies and sine series tables.
`default_nettype none
package uvst_pkg;

	localparam logic CMD_VERTEX = 1'b0;
	localparam logic CMD_QUAD   = 1'b1;

	localparam logic REG_PRECISION = 1'b0;
	localparam logic REG_RADIUS    = 1'b1;

	localparam logic [7:0]  PRECISION_RESET = 8'd16;
	localparam logic [15:0] RADIUS_RESET    = 16'd256;

	localparam int TRIG_FRAC_BITS = 15;

	// Numerator width of the angle and texture divisions, and quotient bits.
	localparam int NUM_W   = 24;
	localparam int DIV_LAT = 17;
	localparam int SIN_LAT = 19;
	localparam int POST_LAT = 4;

	localparam logic [31:0] PI_Q30  = 32'd3373259426;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// Series divisors, innermost term first, and their reciprocals scaled by 2^36.
	localparam int SIN_TERMS = 5;
	localparam logic [6:0] SIN_DIVS [SIN_TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [35:0] SIN_RECIP [SIN_TERMS] = '{
		36'((64'd1 << 36) / 64'd110),
		36'((64'd1 << 36) / 64'd72),
		36'((64'd1 << 36) / 64'd42),
		36'((64'd1 << 36) / 64'd20),
		36'((64'd1 << 36) / 64'd6)
	};

endpackage
`default_nettype wire

// ===== rtl/uvst_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module uvst_div #(
	parameter int PW = 8
) (
	input  wire logic                          clk,
	input  wire logic                          ce,
	input  wire logic [PW-1:0]                 divisor,
	input  wire logic [uvst_pkg::NUM_W-1:0]    num,
	output logic      [uvst_pkg::DIV_LAT-1:0]  quo
);

	localparam int QB = uvst_pkg::DIV_LAT;
	localparam int NW = uvst_pkg::NUM_W;

	logic [PW-1:0] rem_s [QB];
	logic [NW-1:0] num_s [QB];
	logic [QB-1:0] quo_s [QB];

	logic [PW-1:0] rem_in [QB];
	logic [NW-1:0] num_in [QB];
	logic [QB-1:0] quo_in [QB];
	logic [PW:0]   trial  [QB];
	logic          ge     [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		if (k == 0) begin : g_first
			// The quotient fits QB bits, so the top numerator bits are already below the divisor.
			assign rem_in[k] = PW'(num >> QB);
			assign num_in[k] = num;
			assign quo_in[k] = '0;
		end else begin : g_next
			assign rem_in[k] = rem_s[k-1];
			assign num_in[k] = num_s[k-1];
			assign quo_in[k] = quo_s[k-1];
		end

		always_comb begin
			trial[k] = {rem_in[k], num_in[k][QB-1-k]};
			ge[k]    = trial[k] >= {1'b0, divisor};
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k] <= ge[k] ? PW'(trial[k] - {1'b0, divisor}) : PW'(trial[k]);
				num_s[k] <= num_in[k];
				quo_s[k] <= quo_in[k] | (QB'(ge[k]) << (QB - 1 - k));
			end
		end
	end

	assign quo = quo_s[QB-1];

endmodule
`default_nettype wire

// ===== rtl/uvst_sin.sv =====
// Pipelined sine of a 16-bit phase: quarter-wave odd series in Q2.30, result in Q15.
`default_nettype none
module uvst_sin (
	input  wire logic               clk,
	input  wire logic               ce,
	input  wire logic [15:0]        phase,
	output logic signed [16:0]      sin_val
);

	localparam int NT  = uvst_pkg::SIN_TERMS;
	localparam int NB  = 3 * NT + 1;
	localparam int TFB = uvst_pkg::TRIG_FRAC_BITS;

	logic [1:0]  quad;
	logic [13:0] xr;
	logic [14:0] xx;
	logic [46:0] rprod;

	logic [30:0] r_s1;
	logic        neg_s1;

	logic [30:0] r_b   [NB];
	logic [31:0] r2_b  [NB];
	logic        neg_b [NB];

	logic [30:0] t_in    [NT];
	logic [62:0] va_prod [NT];
	logic [31:0] v_a     [NT];
	logic [67:0] qb_prod [NT];
	logic [31:0] q0_b    [NT];
	logic [31:0] v_b     [NT];
	logic [32:0] rem_c   [NT];
	logic [30:0] qf_c    [NT];
	logic [30:0] t_c     [NT];

	logic [30:0] s_f1;
	logic        neg_f1;
	logic [15:0] rnd;

	always_comb begin
		quad  = phase[15:14];
		xr    = phase[13:0];
		xx    = quad[0] ? 15'(15'd16384 - {1'b0, xr}) : {1'b0, xr};
		rprod = 47'(xx) * 47'(uvst_pkg::PI_Q30) + 47'(16384);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			r_s1     <= 31'(rprod >> 15);
			neg_s1   <= quad[1];
			r_b[0]   <= r_s1;
			r2_b[0]  <= 32'((62'(r_s1) * 62'(r_s1)) >> 30);
			neg_b[0] <= neg_s1;
		end
	end

	for (genvar k = 0; k < NT; k++) begin : g_term
		if (k == 0) begin : g_one
			assign t_in[k] = uvst_pkg::ONE_Q30;
		end else begin : g_prev
			assign t_in[k] = t_c[k-1];
		end

		always_comb begin
			va_prod[k] = 63'(r2_b[3*k]) * 63'(t_in[k]);
			qb_prod[k] = 68'(v_a[k]) * 68'(uvst_pkg::SIN_RECIP[k]);
			// The reciprocal estimate is low by at most one; the remainder fixes it.
			rem_c[k]   = 33'(v_b[k]) - 33'(q0_b[k]) * 33'(uvst_pkg::SIN_DIVS[k]);
			qf_c[k]    = 31'(q0_b[k]) +
				((rem_c[k] >= 33'(uvst_pkg::SIN_DIVS[k])) ? 31'd1 : 31'd0);
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				v_a[k]  <= 32'(va_prod[k] >> 30);
				q0_b[k] <= 32'(qb_prod[k] >> 36);
				v_b[k]  <= v_a[k];
				t_c[k]  <= uvst_pkg::ONE_Q30 - qf_c[k];
				for (int m = 0; m < 3; m++) begin
					r_b[3*k+m+1]   <= r_b[3*k+m];
					r2_b[3*k+m+1]  <= r2_b[3*k+m];
					neg_b[3*k+m+1] <= neg_b[3*k+m];
				end
			end
		end
	end

	assign rnd = 16'((32'(s_f1) + (32'd1 << (29 - TFB))) >> (30 - TFB));

	always_ff @(posedge clk) begin
		if (ce) begin
			s_f1    <= 31'((62'(r_b[NB-1]) * 62'(t_c[NT-1])) >> 30);
			neg_f1  <= neg_b[NB-1];
			sin_val <= neg_f1 ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
		end
	end

endmodule
`default_nettype wire

// ===== rtl/uv_sphere_tessellator.sv =====
// Throughput: one request per cycle when the pipeline is not stalled; a vertex gives one word, a quad six words.
// The 41-stage pipeline advances whenever its last stage can move to the output register.
// Reset clears all valid bits and sets precision to 16 and radius to 256.
// Top level of the UV sphere tessellator.
`default_nettype none
module uv_sphere_tessellator #(
	parameter int MAX_PRECISION = 255
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [15:0]   s_tdata,   // ring [7:0], segment [15:8]
	input  wire logic [0:0]    s_tuser,   // cmd [0]
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [167:0]       m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
	                                      // tex_u, tex_v, vertex_index, from bit 0 up
	output logic               m_tlast,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [0:0]    cfg_addr,
	input  wire logic [15:0]   cfg_data
);

	localparam int PW  = $clog2(MAX_PRECISION + 1);
	localparam int NW  = uvst_pkg::NUM_W;
	localparam int QB  = uvst_pkg::DIV_LAT;
	localparam int TFB = uvst_pkg::TRIG_FRAC_BITS;
	localparam int LAT = 1 + uvst_pkg::DIV_LAT + uvst_pkg::SIN_LAT + uvst_pkg::POST_LAT;
	localparam int SD  = LAT - 3;
	localparam int TD  = LAT - 1 - uvst_pkg::DIV_LAT;

	typedef struct packed {
		logic        cmd;
		logic [15:0] c0;
		logic [15:0] c1;
		logic [15:0] c2;
		logic [15:0] c4;
	} side_t;

	typedef struct packed {
		logic [15:0] tex_u;
		logic [15:0] tex_v;
	} tex_t;

	function automatic logic signed [39:0] rnd_away(input logic signed [39:0] v,
		input int unsigned sh);
		logic [39:0] m;
		logic [39:0] r;
		m = (v < 0) ? 40'(-v) : 40'(v);
		r = (m + (40'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
		if (v > 40'sd32767)
			return 16'sh7FFF;
		else if (v < -40'sd32768)
			return -16'sh8000;
		else
			return 16'(v);
	endfunction

	function automatic logic [15:0] sat_idx(input logic [19:0] v);
		return (v > 20'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	// Configuration
	logic [7:0]  precision_q;
	logic [15:0] radius_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_q <= uvst_pkg::PRECISION_RESET;
			radius_q    <= uvst_pkg::RADIUS_RESET;
		end else if (cfg_valid) begin
			case (cfg_addr)
				uvst_pkg::REG_PRECISION: precision_q <= cfg_data[7:0];
				uvst_pkg::REG_RADIUS:    radius_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [10:0]   prec_w;
	logic [PW-1:0] p_eff;
	logic [10:0]   pp1;

	always_comb begin
		prec_w = 11'(precision_q);
		if (prec_w == 11'd0)
			p_eff = PW'(1);
		else if (prec_w > 11'(MAX_PRECISION))
			p_eff = PW'(MAX_PRECISION);
		else
			p_eff = PW'(prec_w);
		pp1 = 11'(p_eff) + 11'd1;
	end

	// Pipeline control
	logic           ce;
	logic           load_ok;
	logic [LAT-1:0] vld_s;

	assign ce       = !vld_s[LAT-1] || load_ok;
	assign s_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (ce)
			vld_s <= {vld_s[LAT-2:0], s_tvalid};
	end

	// Stage 1: clamp indices and form the division numerators.
	logic          in_cmd;
	logic [PW-1:0] lim;
	logic [7:0]    i_sat;
	logic [7:0]    j_sat;

	always_comb begin
		in_cmd = s_tuser[0];
		lim    = (in_cmd == uvst_pkg::CMD_QUAD) ? PW'(p_eff - PW'(1)) : p_eff;
		i_sat  = (11'(s_tdata[7:0]) > 11'(lim)) ? 8'(lim) : s_tdata[7:0];
		j_sat  = (11'(s_tdata[15:8]) > 11'(lim)) ? 8'(lim) : s_tdata[15:8];
	end

	logic          cmd_s1;
	logic [7:0]    i_s1;
	logic [7:0]    j_s1;
	logic [NW-1:0] ath_num_s1;
	logic [NW-1:0] aph_num_s1;
	logic [NW-1:0] tu_num_s1;

	always_ff @(posedge clk) begin
		if (ce) begin
			cmd_s1     <= in_cmd;
			i_s1       <= i_sat;
			j_s1       <= j_sat;
			ath_num_s1 <= NW'({i_sat, 15'd0}) + NW'(p_eff >> 1);
			aph_num_s1 <= NW'({j_sat, 16'd0}) + NW'(p_eff >> 1);
			tu_num_s1  <= NW'({j_sat, 15'd0}) + NW'(p_eff >> 1);
		end
	end

	// Index path: row base, then the corner sums, then a delay line to the end.
	logic        cmd_s2;
	logic [18:0] a0_s2;
	logic [7:0]  j_s2;
	side_t       side_s3;
	side_t       side_sd [SD];
	logic [19:0] c0_w;
	logic [19:0] c2_w;

	always_comb begin
		c0_w = 20'(a0_s2) + 20'(j_s2);
		c2_w = 20'(a0_s2) + 20'(pp1) + 20'(j_s2);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			cmd_s2      <= cmd_s1;
			a0_s2       <= 19'(i_s1) * 19'(pp1);
			j_s2        <= j_s1;
			side_s3.cmd <= cmd_s2;
			side_s3.c0  <= sat_idx(c0_w);
			side_s3.c1  <= sat_idx(c0_w + 20'd1);
			side_s3.c2  <= sat_idx(c2_w);
			side_s3.c4  <= sat_idx(c2_w + 20'd1);
			side_sd[0]  <= side_s3;
			for (int k = 1; k < SD; k++)
				side_sd[k] <= side_sd[k-1];
		end
	end

	// Angle and texture divisions.
	logic [QB-1:0] ath_q;
	logic [QB-1:0] aph_q;
	logic [QB-1:0] tu_q;

	uvst_div #(.PW(PW)) u_div_ath (.clk(clk), .ce(ce), .divisor(p_eff), .num(ath_num_s1),
		.quo(ath_q));
	uvst_div #(.PW(PW)) u_div_aph (.clk(clk), .ce(ce), .divisor(p_eff), .num(aph_num_s1),
		.quo(aph_q));
	uvst_div #(.PW(PW)) u_div_tu  (.clk(clk), .ce(ce), .divisor(p_eff), .num(tu_num_s1),
		.quo(tu_q));

	tex_t tex_sd [TD];

	always_ff @(posedge clk) begin
		if (ce) begin
			tex_sd[0].tex_u <= tu_q[15:0];
			tex_sd[0].tex_v <= ath_q[15:0];
			for (int k = 1; k < TD; k++)
				tex_sd[k] <= tex_sd[k-1];
		end
	end

	// Sines and cosines; a cosine is the sine a quarter turn ahead.
	logic signed [16:0] sth;
	logic signed [16:0] cth;
	logic signed [16:0] sph;
	logic signed [16:0] cph;

	uvst_sin u_sin_th (.clk(clk), .ce(ce), .phase(ath_q[15:0]), .sin_val(sth));
	uvst_sin u_cos_th (.clk(clk), .ce(ce), .phase(ath_q[15:0] + 16'd16384), .sin_val(cth));
	uvst_sin u_sin_ph (.clk(clk), .ce(ce), .phase(aph_q[15:0]), .sin_val(sph));
	uvst_sin u_cos_ph (.clk(clk), .ce(ce), .phase(aph_q[15:0] + 16'd16384), .sin_val(cph));

	// Normal and position math.
	logic signed [39:0] m_s38  [3];
	logic signed [15:0] n_s39  [3];
	logic signed [39:0] pr_s40 [3];
	logic signed [15:0] n_s40  [3];
	logic signed [23:0] pos_s41  [3];
	logic signed [15:0] norm_s41 [3];

	always_ff @(posedge clk) begin
		if (ce) begin
			m_s38[0] <= -(40'(cph) * 40'(sth));
			m_s38[1] <= -40'(cth);
			m_s38[2] <= 40'(sph) * 40'(sth);
			n_s39[0] <= sat16(rnd_away(m_s38[0], TFB));
			n_s39[1] <= sat16(m_s38[1]);
			n_s39[2] <= sat16(rnd_away(m_s38[2], TFB));
			for (int f = 0; f < 3; f++) begin
				pr_s40[f]   <= 40'($signed({1'b0, radius_q})) * 40'(n_s39[f]);
				n_s40[f]    <= n_s39[f];
				pos_s41[f]  <= 24'(rnd_away(pr_s40[f], 8));
				norm_s41[f] <= n_s40[f];
			end
		end
	end

	// Output register; a quad word stays here for six transfers.
	logic               out_valid_q;
	logic [2:0]         k_q;
	side_t              side_q;
	tex_t               tex_q;
	logic signed [23:0] pos_q  [3];
	logic signed [15:0] norm_q [3];
	logic               out_done;
	logic               is_vertex;
	logic [15:0]        vidx;

	assign is_vertex = side_q.cmd == uvst_pkg::CMD_VERTEX;
	assign m_tlast   = is_vertex || k_q == 3'd5;
	assign out_done  = out_valid_q && m_tready && m_tlast;
	assign load_ok   = !out_valid_q || out_done;
	assign m_tvalid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= 3'd0;
		end else if (ce && vld_s[LAT-1]) begin
			out_valid_q <= 1'b1;
			k_q         <= 3'd0;
		end else if (out_done) begin
			out_valid_q <= 1'b0;
			k_q         <= 3'd0;
		end else if (out_valid_q && m_tready) begin
			k_q <= k_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce && vld_s[LAT-1]) begin
			side_q <= side_sd[SD-1];
			tex_q  <= tex_sd[TD-1];
			pos_q  <= pos_s41;
			norm_q <= norm_s41;
		end
	end

	always_comb begin
		case (k_q)
			3'd0:    vidx = side_q.c0;
			3'd1:    vidx = side_q.c1;
			3'd2:    vidx = side_q.c2;
			3'd3:    vidx = side_q.c1;
			3'd4:    vidx = side_q.c4;
			default: vidx = side_q.c2;
		endcase
	end

	always_comb begin
		if (is_vertex)
			m_tdata = {vidx, tex_q.tex_v, tex_q.tex_u, norm_q[2], norm_q[1], norm_q[0],
				pos_q[2], pos_q[1], pos_q[0]};
		else
			m_tdata = {vidx, 152'd0};
	end

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> k_q <= 3'd5)
		else $error("quad word counter ran past the sixth corner");

	a_vertex_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_vertex) |-> k_q == 3'd0)
		else $error("vertex word held a nonzero corner count");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!ce |-> (vld_s[LAT-1] && out_valid_q))
		else $error("pipeline stalled without a word waiting at its end");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(ce && vld_s[LAT-1]) |=> (out_valid_q && k_q == 3'd0))
		else $error("word leaving the pipeline was not loaded into the output register");

endmodule
`default_nettype wire
